FILE: src/sensor_temp_humidity_compensation_macros.svh
// assertion macros shared by the compensation block
`ifndef SENSOR_TEMP_HUMIDITY_COMPENSATION_MACROS_SVH
`define SENSOR_TEMP_HUMIDITY_COMPENSATION_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define STHC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define STHC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sthc_pkg.sv
// types, constants and helpers for the temperature and humidity compensation
`default_nettype none
package sthc_pkg;

    localparam int unsigned TEMP_STAGES = 4;
    localparam int unsigned HUM_STAGES  = 10;

    localparam logic [31:0] TEMP_ROUND      = 32'd128;
    localparam logic [31:0] HUM_FINE_OFFSET = 32'd76800;
    localparam logic [31:0] HUM_P_ROUND     = 32'd16384;
    localparam logic [31:0] HUM_Y_OFFSET    = 32'd32768;
    localparam logic [31:0] HUM_Q_OFFSET    = 32'd2097152;
    localparam logic [31:0] HUM_Q_ROUND     = 32'd8192;
    localparam logic [31:0] HUM_CLAMP_MAX   = 32'd419430400;
    localparam logic [16:0] HUM_HQ_MAX      = 17'd102400;
    localparam logic [23:0] HUM_PCT_SCALE   = 24'd100;
    localparam logic [23:0] HUM_PCT_ROUND   = 24'd512;
    localparam logic [13:0] HUM_CAP         = 14'd10000;

    typedef enum logic [2:0] {
        REG_TEMP_CAL_ONE      = 3'd0,
        REG_TEMP_CAL_TWO      = 3'd1,
        REG_TEMP_CAL_THREE    = 3'd2,
        REG_HUM_CAL_ONE       = 3'd3,
        REG_HUM_CAL_TWO       = 3'd4,
        REG_HUM_CAL_THREE     = 3'd5,
        REG_HUM_CAL_FOUR_FIVE = 3'd6,
        REG_HUM_CAL_SIX       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] temp_cal_one;
        logic [15:0] temp_cal_two;
        logic [15:0] temp_cal_three;
        logic [7:0]  hum_cal_one;
        logic [15:0] hum_cal_two;
        logic [7:0]  hum_cal_three;
        logic [23:0] hum_cal_four_five;
        logic [7:0]  hum_cal_six;
    } cal_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] fine_offset;
        logic [15:0] temperature;
        logic [15:0] raw_humidity;
    } temp_stage_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] sh);
        return $unsigned($signed(x) >>> sh);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sext12(input logic [11:0] x);
        return {{20{x[11]}}, x};
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

endpackage
`default_nettype wire

FILE: src/sthc_cfg.sv
// calibration register file behind the apb-style port
`default_nettype none
module sthc_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output sthc_pkg::cal_t     cal
);

    sthc_pkg::cal_t     cal_reg;
    sthc_pkg::cal_t     cal_next;
    sthc_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = sthc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cal_next = cal_reg;
        if (wr_en) begin
            unique case (idx)
                sthc_pkg::REG_TEMP_CAL_ONE:      cal_next.temp_cal_one      = pwdata[15:0];
                sthc_pkg::REG_TEMP_CAL_TWO:      cal_next.temp_cal_two      = pwdata[15:0];
                sthc_pkg::REG_TEMP_CAL_THREE:    cal_next.temp_cal_three    = pwdata[15:0];
                sthc_pkg::REG_HUM_CAL_ONE:       cal_next.hum_cal_one       = pwdata[7:0];
                sthc_pkg::REG_HUM_CAL_TWO:       cal_next.hum_cal_two       = pwdata[15:0];
                sthc_pkg::REG_HUM_CAL_THREE:     cal_next.hum_cal_three     = pwdata[7:0];
                sthc_pkg::REG_HUM_CAL_FOUR_FIVE: cal_next.hum_cal_four_five = pwdata[23:0];
                sthc_pkg::REG_HUM_CAL_SIX:       cal_next.hum_cal_six       = pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            sthc_pkg::REG_TEMP_CAL_ONE:      prdata = {16'b0, cal_reg.temp_cal_one};
            sthc_pkg::REG_TEMP_CAL_TWO:      prdata = {16'b0, cal_reg.temp_cal_two};
            sthc_pkg::REG_TEMP_CAL_THREE:    prdata = {16'b0, cal_reg.temp_cal_three};
            sthc_pkg::REG_HUM_CAL_ONE:       prdata = {24'b0, cal_reg.hum_cal_one};
            sthc_pkg::REG_HUM_CAL_TWO:       prdata = {16'b0, cal_reg.hum_cal_two};
            sthc_pkg::REG_HUM_CAL_THREE:     prdata = {24'b0, cal_reg.hum_cal_three};
            sthc_pkg::REG_HUM_CAL_FOUR_FIVE: prdata = {8'b0, cal_reg.hum_cal_four_five};
            sthc_pkg::REG_HUM_CAL_SIX:       prdata = {24'b0, cal_reg.hum_cal_six};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule
`default_nettype wire

FILE: src/sthc_temp.sv
// temperature pipeline: fine temperature and centi-degrees, four stages
`default_nettype none
`include "sensor_temp_humidity_compensation_macros.svh"
module sthc_temp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [19:0]          raw_temperature,
    input  wire logic [15:0]          raw_humidity,
    input  wire sthc_pkg::cal_t       cal,
    output sthc_pkg::temp_stage_t     out
);

    logic [sthc_pkg::TEMP_STAGES-1:0] valid_reg;
    logic [sthc_pkg::TEMP_STAGES-1:0] valid_next;

    logic [31:0] a_reg, a_next, b_reg, b_next;
    logic [31:0] m1_reg, m1_next, bb_reg, bb_next;
    logic [31:0] var1_reg, var1_next, m3_reg, m3_next;
    logic [31:0] fine;
    logic [31:0] temp_full;
    logic [31:0] v_reg, v_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] hum_reg [sthc_pkg::TEMP_STAGES];
    logic [15:0] hum_next [sthc_pkg::TEMP_STAGES];

    always_comb begin
        valid_next = valid_reg;
        if (en) begin
            valid_next = {valid_reg[sthc_pkg::TEMP_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // stage 1: offsets
    assign a_next = {15'b0, raw_temperature[19:3]} - {15'b0, cal.temp_cal_one, 1'b0};
    assign b_next = {16'b0, raw_temperature[19:4]} - {16'b0, cal.temp_cal_one};

    // stage 2: products
    assign m1_next = a_reg * sthc_pkg::sext16(cal.temp_cal_two);
    assign bb_next = b_reg * b_reg;

    // stage 3
    assign var1_next = sthc_pkg::asr32(m1_reg, 5'd11);
    assign m3_next   = sthc_pkg::asr32(bb_reg, 5'd12) * sthc_pkg::sext16(cal.temp_cal_three);

    // stage 4: fine temperature, rounded centi-degrees
    assign fine      = var1_reg + sthc_pkg::asr32(m3_reg, 5'd14);
    assign temp_full = {fine[29:0], 2'b0} + fine + sthc_pkg::TEMP_ROUND;
    assign temp_next = temp_full[23:8];
    assign v_next    = fine - sthc_pkg::HUM_FINE_OFFSET;

    always_comb begin
        hum_next[0] = raw_humidity;
        for (int i = 1; i < sthc_pkg::TEMP_STAGES; i++) begin
            hum_next[i] = hum_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            m1_reg   <= m1_next;
            bb_reg   <= bb_next;
            var1_reg <= var1_next;
            m3_reg   <= m3_next;
            v_reg    <= v_next;
            temp_reg <= temp_next;
            for (int i = 0; i < sthc_pkg::TEMP_STAGES; i++) begin
                hum_reg[i] <= hum_next[i];
            end
        end
    end

    assign out.valid        = valid_reg[sthc_pkg::TEMP_STAGES-1];
    assign out.fine_offset  = v_reg;
    assign out.temperature  = temp_reg;
    assign out.raw_humidity = hum_reg[sthc_pkg::TEMP_STAGES-1];

    `STHC_ASSERT_NXT(a_temp_stall_hold, !en, $stable(valid_reg), "temp valids moved in stall")
    `STHC_ASSERT_NXT(a_temp_advance, en && valid_reg[0], valid_reg[1], "temp item lost")
    `STHC_ASSERT_NXT(a_temp_enter, en && in_valid, valid_reg[0], "temp item not taken")

endmodule
`default_nettype wire

FILE: src/sthc_hum.sv
// humidity pipeline and output register, ten stages
`default_nettype none
`include "sensor_temp_humidity_compensation_macros.svh"
module sthc_hum (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire sthc_pkg::temp_stage_t in,
    input  wire sthc_pkg::cal_t       cal,
    output logic                      out_valid,
    output logic [15:0]               temperature_centi_deg,
    output logic [13:0]               humidity_centi_pct
);

    localparam int unsigned N = sthc_pkg::HUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [15:0]  temp_reg [N];
    logic [15:0]  temp_next [N];

    logic [31:0] h2x, h4x, h5x, h6x;

    logic [31:0] hv5_reg, hv5_next, v6_reg, v6_next, v3_reg, v3_next;
    logic [15:0] adch_reg;
    logic [31:0] p6_reg, p6_next, x_reg, x_next, y_reg, y_next;
    logic [31:0] q0_reg, q0_next, p7_reg;
    logic [31:0] m8_reg, m8_next, p8_reg;
    logic [31:0] q_reg, q_next, p9_reg;
    logic [31:0] vv10_reg, vv10_next;
    logic [31:0] r11;
    logic [31:0] rr_reg, rr_next, vv11_reg;
    logic [31:0] r2_reg, r2_next, vv12_reg;
    logic [31:0] d13, clamped;
    logic [16:0] hq_reg, hq_next;
    logic [23:0] pct;
    logic [13:0] hout_reg, hout_next;

    assign h2x = sthc_pkg::sext16(cal.hum_cal_two);
    assign h4x = sthc_pkg::sext12(cal.hum_cal_four_five[11:0]);
    assign h5x = sthc_pkg::sext12(cal.hum_cal_four_five[23:12]);
    assign h6x = sthc_pkg::sext8(cal.hum_cal_six);

    always_comb begin
        valid_next = valid_reg;
        if (en) begin
            valid_next = {valid_reg[N-2:0], in.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        temp_next[0] = in.temperature;
        for (int i = 1; i < N; i++) begin
            temp_next[i] = temp_reg[i-1];
        end
    end

    // stage 5: three products on the fine offset
    assign hv5_next = h5x * in.fine_offset;
    assign v6_next  = in.fine_offset * h6x;
    assign v3_next  = in.fine_offset * {24'b0, cal.hum_cal_three};

    // stage 6
    assign p6_next = sthc_pkg::asr32({2'b0, adch_reg, 14'b0} - {h4x[11:0], 20'b0} - hv5_reg
                                     + sthc_pkg::HUM_P_ROUND, 5'd15);
    assign x_next  = sthc_pkg::asr32(v6_reg, 5'd10);
    assign y_next  = sthc_pkg::asr32(v3_reg, 5'd11) + sthc_pkg::HUM_Y_OFFSET;

    // stage 7
    assign q0_next = x_reg * y_reg;

    // stage 8
    assign m8_next = (sthc_pkg::asr32(q0_reg, 5'd10) + sthc_pkg::HUM_Q_OFFSET) * h2x;

    // stage 9
    assign q_next = sthc_pkg::asr32(m8_reg + sthc_pkg::HUM_Q_ROUND, 5'd14);

    // stage 10
    assign vv10_next = p9_reg * q_reg;

    // stage 11
    assign r11     = sthc_pkg::asr32(vv10_reg, 5'd15);
    assign rr_next = r11 * r11;

    // stage 12
    assign r2_next = sthc_pkg::asr32(rr_reg, 5'd7) * {24'b0, cal.hum_cal_one};

    // stage 13: clamp to full scale
    assign d13 = vv12_reg - sthc_pkg::asr32(r2_reg, 5'd4);
    always_comb begin
        if (d13[31]) begin
            clamped = '0;
        end else if (d13 > sthc_pkg::HUM_CLAMP_MAX) begin
            clamped = sthc_pkg::HUM_CLAMP_MAX;
        end else begin
            clamped = d13;
        end
    end
    assign hq_next = clamped[28:12];

    // stage 14: rescale to centi-percent
    assign pct = {7'b0, hq_reg} * sthc_pkg::HUM_PCT_SCALE + sthc_pkg::HUM_PCT_ROUND;
    always_comb begin
        if (pct[23:10] > sthc_pkg::HUM_CAP) begin
            hout_next = sthc_pkg::HUM_CAP;
        end else begin
            hout_next = pct[23:10];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hv5_reg  <= hv5_next;
            v6_reg   <= v6_next;
            v3_reg   <= v3_next;
            adch_reg <= in.raw_humidity;
            p6_reg   <= p6_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            q0_reg   <= q0_next;
            p7_reg   <= p6_reg;
            m8_reg   <= m8_next;
            p8_reg   <= p7_reg;
            q_reg    <= q_next;
            p9_reg   <= p8_reg;
            vv10_reg <= vv10_next;
            rr_reg   <= rr_next;
            vv11_reg <= vv10_reg;
            r2_reg   <= r2_next;
            vv12_reg <= vv11_reg;
            hq_reg   <= hq_next;
            hout_reg <= hout_next;
            for (int i = 0; i < N; i++) begin
                temp_reg[i] <= temp_next[i];
            end
        end
    end

    assign out_valid             = valid_reg[N-1];
    assign temperature_centi_deg = temp_reg[N-1];
    assign humidity_centi_pct    = hout_reg;

    `STHC_ASSERT_IMP(a_hum_cap, out_valid, hout_reg <= sthc_pkg::HUM_CAP, "humidity above cap")
    `STHC_ASSERT_IMP(a_hq_range, valid_reg[N-2], hq_reg <= sthc_pkg::HUM_HQ_MAX, "hq out of range")
    `STHC_ASSERT_NXT(a_hum_stall_hold, !en, $stable(valid_reg), "hum valids moved in stall")

endmodule
`default_nettype wire

FILE: src/sensor_temp_humidity_compensation.sv
// Temperature and humidity compensation for a combined sensor. One item carries a raw
// 20-bit temperature and a raw 16-bit humidity reading and yields one item with
// centi-degrees and centi-percent. The datapath is a 14-stage pipeline that takes a new
// item every cycle unless the output stalls; m_tvalid rises when an accepted item leaves
// the last stage. A stall on the output freezes every stage at once, so s_tready follows
// m_tready while the output register is full. Calibration registers sit at byte address
// 4*index on the apb port and should be written only while no item is in flight.
`default_nettype none
module sensor_temp_humidity_compensation (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temperature[19:0], raw_humidity[35:20]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // temperature_centi_deg[15:0], humidity_centi_pct[29:16]
    // calibration registers
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    sthc_pkg::cal_t        cal;
    sthc_pkg::temp_stage_t temp_out;
    logic                  en;
    logic                  out_valid;
    logic [15:0]           temperature_centi_deg;
    logic [13:0]           humidity_centi_pct;

    // whole pipeline advances unless a result is waiting and m_tready is low
    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    sthc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    sthc_temp u_temp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_valid        (s_tvalid),
        .raw_temperature (s_tdata[19:0]),
        .raw_humidity    (s_tdata[35:20]),
        .cal             (cal),
        .out             (temp_out)
    );

    sthc_hum u_hum (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .en                    (en),
        .in                    (temp_out),
        .cal                   (cal),
        .out_valid             (out_valid),
        .temperature_centi_deg (temperature_centi_deg),
        .humidity_centi_pct    (humidity_centi_pct)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {2'b0, humidity_centi_pct, temperature_centi_deg};

endmodule
`default_nettype wire

FILE: sim/tb_sensor_temp_humidity_compensation.sv
// testbench for the temperature and humidity compensation block: scoreboard against a predictor
module tb_sensor_temp_humidity_compensation;

    localparam int LIMIT_TIME = 24_000_000;

    typedef struct packed {
        logic [15:0] temp_centi;
        logic [13:0] hum_centi;
    } reading_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // raw_temperature[19:0], raw_humidity[35:20]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // temperature_centi_deg[15:0], humidity_centi_pct[29:16]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    sthc_pkg::cal_t cal_model = '0;
    reading_t pending_readings[$];
    int       mismatches = 0;
    bit       burst_mode = 1'b0;
    bit       rx_random  = 1'b0;
    int       rx_stall_left = 0;

    sensor_temp_humidity_compensation dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("[sensor_temp_humidity_compensation] ERROR");
        $finish;
    end

    function automatic logic [31:0] shr_s(input logic [31:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic reading_t compensate_reading(input logic [19:0] raw_t,
                                                    input logic [15:0] raw_h);
        logic [31:0] adc_t, adc_h, t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, var1, var2, fine, temp, v, p, q, r, hq, h100;
        reading_t res;
        adc_t = {12'b0, raw_t};
        adc_h = {16'b0, raw_h};
        t1 = {16'b0, cal_model.temp_cal_one};
        t2 = {{16{cal_model.temp_cal_two[15]}}, cal_model.temp_cal_two};
        t3 = {{16{cal_model.temp_cal_three[15]}}, cal_model.temp_cal_three};
        h1 = {24'b0, cal_model.hum_cal_one};
        h2 = {{16{cal_model.hum_cal_two[15]}}, cal_model.hum_cal_two};
        h3 = {24'b0, cal_model.hum_cal_three};
        h4 = {{20{cal_model.hum_cal_four_five[11]}}, cal_model.hum_cal_four_five[11:0]};
        h5 = {{20{cal_model.hum_cal_four_five[23]}}, cal_model.hum_cal_four_five[23:12]};
        h6 = {{24{cal_model.hum_cal_six[7]}}, cal_model.hum_cal_six};

        a    = (adc_t >> 3) - (t1 << 1);
        var1 = shr_s(a * t2, 11);
        b    = (adc_t >> 4) - t1;
        var2 = shr_s(shr_s(b * b, 12) * t3, 14);
        fine = var1 + var2;
        temp = shr_s(fine * 32'd5 + 32'd128, 8);

        v = fine - 32'd76800;
        p = (adc_h << 14) - (h4 << 20) - (h5 * v) + 32'd16384;
        p = shr_s(p, 15);
        q = shr_s(v * h6, 10) * (shr_s(v * h3, 11) + 32'd32768);
        q = shr_s(q, 10) + 32'd2097152;
        q = shr_s(q * h2 + 32'd8192, 14);
        v = p * q;
        r = shr_s(v, 15);
        r = shr_s(r * r, 7);
        r = shr_s(r * h1, 4);
        v = v - r;
        if (v[31]) begin
            v = 32'd0;
        end else if (v > 32'd419430400) begin
            v = 32'd419430400;
        end
        hq   = v >> 12;
        h100 = (hq * 32'd100 + 32'd512) >> 10;
        if (h100 > 32'd10000) begin
            h100 = 32'd10000;
        end
        res.temp_centi = temp[15:0];
        res.hum_centi  = h100[13:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : scoreboard
        reading_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("result item with none pending", m_tdata, '0);
                end else begin
                    want = pending_readings.pop_front();
                    if (m_tdata[15:0] !== want.temp_centi)
                        report_mismatch("temperature_centi_deg", {16'b0, m_tdata[15:0]},
                                        {16'b0, want.temp_centi});
                    if (m_tdata[29:16] !== want.hum_centi)
                        report_mismatch("humidity_centi_pct", {18'b0, m_tdata[29:16]},
                                        {18'b0, want.hum_centi});
                end
            end
            if (s_tvalid && s_tready)
                pending_readings.push_back(compensate_reading(s_tdata[19:0], s_tdata[35:20]));
        end
    end

    // result side pacing
    always @(posedge aclk) begin : rx_pace
        logic nxt;
        int   r;
        if (!rx_random) begin
            nxt = 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            nxt = 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                nxt = 1'b1;
            end else begin
                nxt = 1'b0;
                rx_stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
            end
        end
        m_tready <= nxt;
    end

    task automatic send_reading(input logic [19:0] raw_t, input logic [15:0] raw_h);
        int gap, r;
        gap = 0;
        if (!burst_mode) begin
            r = $urandom_range(0, 99);
            if (r < 60)      gap = 0;
            else if (r < 90) gap = $urandom_range(1, 3);
            else if (r < 97) gap = $urandom_range(4, 10);
            else             gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, raw_h, raw_t};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_reading();
        logic [19:0] raw_t;
        logic [15:0] raw_h;
        raw_t = $urandom_range(0, 1) ? 20'($urandom_range(0, 20'hFFFFF))
                                     : 20'($urandom_range(400000, 600000));
        raw_h = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'hFFFF))
                                     : 16'($urandom_range(15000, 55000));
        send_reading(raw_t, raw_h);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic cal_write(input sthc_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] kept, readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            sthc_pkg::REG_TEMP_CAL_ONE: begin
                cal_model.temp_cal_one = value[15:0];
                kept = {16'b0, value[15:0]};
            end
            sthc_pkg::REG_TEMP_CAL_TWO: begin
                cal_model.temp_cal_two = value[15:0];
                kept = {16'b0, value[15:0]};
            end
            sthc_pkg::REG_TEMP_CAL_THREE: begin
                cal_model.temp_cal_three = value[15:0];
                kept = {16'b0, value[15:0]};
            end
            sthc_pkg::REG_HUM_CAL_ONE: begin
                cal_model.hum_cal_one = value[7:0];
                kept = {24'b0, value[7:0]};
            end
            sthc_pkg::REG_HUM_CAL_TWO: begin
                cal_model.hum_cal_two = value[15:0];
                kept = {16'b0, value[15:0]};
            end
            sthc_pkg::REG_HUM_CAL_THREE: begin
                cal_model.hum_cal_three = value[7:0];
                kept = {24'b0, value[7:0]};
            end
            sthc_pkg::REG_HUM_CAL_FOUR_FIVE: begin
                cal_model.hum_cal_four_five = value[23:0];
                kept = {8'b0, value[23:0]};
            end
            sthc_pkg::REG_HUM_CAL_SIX: begin
                cal_model.hum_cal_six = value[7:0];
                kept = {24'b0, value[7:0]};
            end
        endcase
        @(posedge aclk);
        // read back
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (readback !== kept) report_mismatch($sformatf("readback of %s", idx.name()),
                                               readback, kept);
    endtask

    task automatic set_cal(input logic [31:0] t1, input logic [31:0] t2, input logic [31:0] t3,
                           input logic [31:0] h1, input logic [31:0] h2, input logic [31:0] h3,
                           input logic [31:0] h45, input logic [31:0] h6);
        cal_write(sthc_pkg::REG_TEMP_CAL_ONE, t1);
        cal_write(sthc_pkg::REG_TEMP_CAL_TWO, t2);
        cal_write(sthc_pkg::REG_TEMP_CAL_THREE, t3);
        cal_write(sthc_pkg::REG_HUM_CAL_ONE, h1);
        cal_write(sthc_pkg::REG_HUM_CAL_TWO, h2);
        cal_write(sthc_pkg::REG_HUM_CAL_THREE, h3);
        cal_write(sthc_pkg::REG_HUM_CAL_FOUR_FIVE, h45);
        cal_write(sthc_pkg::REG_HUM_CAL_SIX, h6);
    endtask

    // all calibration registers still at reset
    task automatic test_reset_cal();
        burst_mode = 1'b0;
        rx_random  = 1'b1;
        repeat (8) send_random_reading();
        wait_drained();
    endtask

    // typical chip calibration, field extremes and clamp cases
    task automatic test_typical_cal();
        logic [19:0] temps[12];
        logic [15:0] hums[12];
        temps = '{20'h0, 20'hFFFFF, 20'h0, 20'hFFFFF, 20'd519888, 20'd519888,
                  20'd519888, 20'd415148, 20'd600000, 20'h80000, 20'h7FFFF, 20'h1};
        hums  = '{16'h0, 16'hFFFF, 16'hFFFF, 16'h0, 16'd30000, 16'h0,
                  16'hFFFF, 16'd20000, 16'd50000, 16'h8000, 16'h7FFF, 16'h1};
        set_cal(32'd27504, 32'd26435, -32'sd1000, 32'd75, 32'd362, 32'd0,
                (32'd50 << 12) | 32'd313, 32'd30);
        burst_mode = 1'b1;
        rx_random  = 1'b0;
        foreach (temps[i]) send_reading(temps[i], hums[i]);
        wait_drained();
    endtask

    // calibration at the ends of each register's range, upper bits of pwdata set
    task automatic test_extreme_cal();
        set_cal('1, '1, '1, '1, '1, '1, '1, '1);
        burst_mode = 1'b0;
        rx_random  = 1'b1;
        repeat (70) send_random_reading();
        wait_drained();
        set_cal(32'hFFFF_0000, 32'h0000_8000, 32'h0000_8000, 32'hFFFF_FF00,
                32'h0000_8000, 32'h0000_0000, 32'hFF80_0800, 32'h0000_0080);
        burst_mode = 1'b1;
        repeat (70) send_random_reading();
        wait_drained();
        set_cal(32'h0000_FFFF, 32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_00FF,
                32'h0000_7FFF, 32'h0000_00FF, 32'h007F_F7FF, 32'h0000_007F);
        burst_mode = 1'b0;
        rx_random  = 1'b0;
        repeat (70) send_random_reading();
        wait_drained();
    endtask

    // random calibration sets, near-typical and fully random
    task automatic test_random_cal();
        for (int ph = 0; ph < 6; ph++) begin
            if ($urandom_range(0, 1)) begin
                set_cal(27000 + $urandom_range(0, 2000), 25000 + $urandom_range(0, 3000),
                        -$urandom_range(0, 2000), 60 + $urandom_range(0, 30),
                        330 + $urandom_range(0, 70), $urandom_range(0, 10),
                        ($urandom_range(0, 60) << 12) | (280 + $urandom_range(0, 60)),
                        20 + $urandom_range(0, 20));
            end else begin
                set_cal($urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom(), $urandom());
            end
            burst_mode = (ph % 3 == 0);
            rx_random  = (ph % 2 == 0) || (ph == 5);
            repeat (145) send_random_reading();
            // sender holds off until every pending result is back
            wait_drained();
            repeat (145) send_random_reading();
            wait_drained();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_cal();
        test_typical_cal();
        test_extreme_cal();
        test_random_cal();
        wait_drained();
        repeat (30) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[sensor_temp_humidity_compensation] OK");
        end else begin
            $display("[sensor_temp_humidity_compensation] ERROR");
        end
        $finish;
    end

endmodule
